[sv/cl2_pkg.sv]
// Shared types, constants and the atanh/ln2 table for the CORDIC log2 unit.
package cl2_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned IdxW   = 6;   // CORDIC shift index 0..61
  localparam int unsigned StepW  = 7;   // step / stage counter, 0..64
  localparam int unsigned NormSt = 6;   // normalization stages: 32,16,8,4,2,1
  localparam int unsigned NumSteps = 65;

  localparam logic [DataW-1:0] OneQ61 = 64'h2000_0000_0000_0000;

  // Controller to datapath commands.
  typedef struct packed {
    logic           load;    // capture operand
    logic           norm;    // one normalization stage
    logic [2:0]     nstage;  // which stage: shift by 32 >> nstage
    logic           init;    // set x, y, z from the mantissa
    logic           iter;    // one CORDIC step
    logic [IdxW-1:0] idx;    // shift index of this step
    logic           fin;     // round and load the result register
  } cl2_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pow2;  // mantissa is exactly 1.0
    logic inv;   // operand was zero or negative
  } cl2_stat_t;

  // atanh(2^-(i+1))*2/ln2 scaled so that >> i gives the Q61 z increment.
  function automatic logic [DataW-1:0] cl2_atanh(input logic [4:0] t);
    logic [DataW-1:0] r;
    unique case (t)
      5'd0:  r = 64'h32B803473F7AD0F4;
      5'd1:  r = 64'h2F2A71BD4E25E916;
      5'd2:  r = 64'h2E68B244BB93BA06;
      5'd3:  r = 64'h2E39FB9198CE62E4;
      5'd4:  r = 64'h2E2E683F68565C8F;
      5'd5:  r = 64'h2E2B850BE2077FC1;
      5'd6:  r = 64'h2E2ACC58FE7B78DB;
      5'd7:  r = 64'h2E2A9E2DE52FD5F2;
      5'd8:  r = 64'h2E2A92A338D53EEC;
      5'd9:  r = 64'h2E2A8FC08F5E19B6;
      5'd10: r = 64'h2E2A8F07E51A485E;
      5'd11: r = 64'h2E2A8ED9BA8AF388;
      5'd12: r = 64'h2E2A8ECE2FE7384A;
      5'd13: r = 64'h2E2A8ECB4D3E4B1A;
      5'd14: r = 64'h2E2A8ECA94940FE8;
      5'd15: r = 64'h2E2A8ECA6669811D;
      5'd16: r = 64'h2E2A8ECA5ADEDD6A;
      5'd17: r = 64'h2E2A8ECA57FC347E;
      5'd18: r = 64'h2E2A8ECA57438A43;
      5'd19: r = 64'h2E2A8ECA57155FB4;
      5'd20: r = 64'h2E2A8ECA5709D510;
      5'd21: r = 64'h2E2A8ECA5706F267;
      5'd22: r = 64'h2E2A8ECA570639BD;
      5'd23: r = 64'h2E2A8ECA57060B92;
      5'd24: r = 64'h2E2A8ECA57060008;
      5'd25: r = 64'h2E2A8ECA5705FD25;
      5'd26: r = 64'h2E2A8ECA5705FC6C;
      5'd27: r = 64'h2E2A8ECA5705FC3E;
      5'd28: r = 64'h2E2A8ECA5705FC33;
      5'd29: r = 64'h2E2A8ECA5705FC30;
      default: r = 64'h2E2A8ECA5705FC2F;
    endcase
    return r;
  endfunction

endpackage

[sv/cl2_if.sv]
// Valid/ready channel interfaces for operand and result words.
interface cl2_arg_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] operand;
  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

interface cl2_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] log_q57;
  logic               invalid;
  modport source (output valid, output log_q57, output invalid, input ready);
  modport sink   (input valid, input log_q57, input invalid, output ready);
endinterface

[sv/cordic_log2_q57_unit.sv]
// Top level of the Q57 base-2 logarithm unit (hyperbolic vectoring CORDIC).
//
// Channels: arg carries one signed 64-bit operand word per handshake; res
// returns one word per operand: log_q57 (log2 in Q57) and invalid. A word
// moves at a rising edge with valid and ready both high.
// Operation: a zero or negative operand gives log_q57 = -1, invalid = 1.
// Otherwise the leading one is found by a six-stage binary search (one
// stage a cycle), the Q61 mantissa m seeds x = m+1, y = m-1, and one shared
// CORDIC stage runs 65 steps (indices 3, 12 and 39 twice) accumulating z.
// The result is p*2^57 + ((z+8) >>> 4).
// Sequence: accept, the six normalize stages, init, the CORDIC steps and
// the result stage, which loads the result register. Powers of two and
// invalid operands skip the CORDIC. One operand is in flight at a time;
// the iteration count of the shared stage sets the rate: the next operand
// is taken once the last result has been loaded into the result register.
// Reset (rst, synchronous) empties the controller and the result register.
// A stalled receiver holds the result; arg is taken again once the unit is
// idle, and a finished result waits in its stage until the register frees.
module cordic_log2_q57_unit (
  input  logic      clk,
  input  logic      rst,
  cl2_arg_if.sink   arg,
  cl2_res_if.source res
);
  import cl2_pkg::*;

  cl2_cmd_t  cmd;
  cl2_stat_t stat;
  logic [63:0] log_q57;
  logic        invalid;

  cl2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg.valid),
    .arg_ready (arg.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cl2_dp u_dp (
    .clk     (clk),
    .operand (arg.operand),
    .cmd     (cmd),
    .stat    (stat),
    .log_q57 (log_q57),
    .invalid (invalid)
  );

  assign res.log_q57 = log_q57;
  assign res.invalid = invalid;

endmodule

[sv/cl2_dp.sv]
// Datapath: normalizer, shared CORDIC stage and result register.
module cl2_dp (
  input  logic                 clk,
  input  logic [63:0]          operand,
  input  cl2_pkg::cl2_cmd_t    cmd,
  output cl2_pkg::cl2_stat_t   stat,
  output logic [63:0]          log_q57,
  output logic                 invalid
);
  import cl2_pkg::*;

  logic [62:0]      v;       // normalized value, leading one ends at bit 62
  logic [IdxW-1:0]  p;       // leading-one position
  logic             inv;
  logic [DataW-1:0] x, y, z;

  // normalization stage
  logic [IdxW-1:0]  nsh;
  logic [62:0]      nmask;

  // CORDIC step
  logic [StepW-1:0] sh1;
  logic [4:0]       tix;
  logic [DataW-1:0] a, xs, ys;

  // rounding
  logic [DataW-1:0] zr;

  always_comb begin
    nsh   = IdxW'(6'd32 >> cmd.nstage);
    nmask = ~({63{1'b1}} >> nsh);
    sh1   = StepW'(cmd.idx) + StepW'(1);
    tix   = (cmd.idx > IdxW'(31)) ? 5'd31 : cmd.idx[4:0];
    a     = cl2_atanh(tix) >> cmd.idx;
    xs    = DataW'($signed(x) >>> sh1);
    ys    = DataW'($signed(y) >>> sh1);
    zr    = DataW'($signed(z + DataW'(8)) >>> 4);
  end

  assign stat.pow2 = (v[61:1] == '0);
  assign stat.inv  = inv;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= operand[62:0];
      p   <= IdxW'(62);
      inv <= operand[63] | (operand == '0);
    end else if (cmd.norm) begin
      if ((v & nmask) == '0) begin
        v <= v << nsh;
        p <= p - nsh;
      end
    end
    if (cmd.init) begin
      // mantissa m = v >> 1 in Q61
      x <= {2'b00, v[62:1]} + OneQ61;
      y <= {2'b00, v[62:1]} - OneQ61;
      z <= '0;
    end else if (cmd.iter) begin
      if (y[63]) begin
        z <= z - a;
        x <= x + ys;
        y <= y + xs;
      end else begin
        z <= z + a;
        x <= x - ys;
        y <= y - xs;
      end
    end
    if (cmd.fin) begin
      invalid <= inv;
      log_q57 <= inv ? '1 : ({1'b0, p, 57'b0} + zr);
    end
  end

endmodule

[sv/cl2_ctrl.sv]
// Controller: sequences load, normalization, CORDIC steps and result handoff.
module cl2_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 arg_valid,
  output logic                 arg_ready,
  output logic                 res_valid,
  input  logic                 res_ready,
  input  cl2_pkg::cl2_stat_t   stat,
  output cl2_pkg::cl2_cmd_t    cmd
);
  import cl2_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state, state_next;
  logic [StepW-1:0] cnt, cnt_next;
  logic             fire;
  logic [StepW-1:0] idx_w;

  assign arg_ready = (state == S_IDLE);
  assign fire      = (state == S_FIN) && (!res_valid || res_ready);

  // step number -> shift index: 0..3, 3..12, 12..31, 32..39, 39..61
  always_comb begin
    priority if (cnt < StepW'(4))  idx_w = cnt;
    else if (cnt < StepW'(14))     idx_w = cnt - StepW'(1);
    else if (cnt < StepW'(42))     idx_w = cnt - StepW'(2);
    else                           idx_w = cnt - StepW'(3);
  end

  always_comb begin
    cmd.load   = arg_valid && arg_ready;
    cmd.norm   = (state == S_NORM);
    cmd.nstage = cnt[2:0];
    cmd.init   = (state == S_INIT);
    cmd.iter   = (state == S_ITER);
    cmd.idx    = idx_w[IdxW-1:0];
    cmd.fin    = fire;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (arg_valid) begin
          state_next = S_NORM;
          cnt_next   = '0;
        end
      end
      S_NORM: begin
        if (cnt == StepW'(NormSt - 1)) state_next = S_INIT;
        else cnt_next = cnt + StepW'(1);
      end
      S_INIT: begin
        cnt_next   = '0;
        state_next = (stat.pow2 || stat.inv) ? S_FIN : S_ITER;
      end
      S_ITER: begin
        if (cnt == StepW'(NumSteps - 1)) state_next = S_FIN;
        else cnt_next = cnt + StepW'(1);
      end
      S_FIN: begin
        if (fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (fire) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

endmodule
